// File: src/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// shared constants and types for the sensor reply frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 26;
  localparam int unsigned SUM_BYTES   = 24;
  localparam int unsigned POS_W       = 5;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HDR0  = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR1  = 5'd1;
  localparam logic [POS_W-1:0] POS_CMD_L = 5'd4;
  localparam logic [POS_W-1:0] POS_CMD_H = 5'd5;
  localparam logic [POS_W-1:0] POS_PAY_L = 5'd10;
  localparam logic [POS_W-1:0] POS_PAY_H = 5'd11;
  localparam logic [POS_W-1:0] POS_CHK_L = 5'd24;
  localparam logic [POS_W-1:0] POS_CHK_H = 5'd25;
  localparam logic [POS_W-1:0] POS_FULL  = 5'd26;
  localparam logic [POS_W-1:0] POS_SUM   = 5'd24;

  // header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h55;

  // status query answer meaning the id is already taken
  localparam logic [7:0] ID_TAKEN = 8'h01;

  // reply command words
  localparam logic [15:0] CMD_STATUS        = 16'h0046;
  localparam logic [15:0] CMD_IMAGE         = 16'h0020;
  localparam logic [15:0] CMD_MAKE_TEMPLATE = 16'h0060;
  localparam logic [15:0] CMD_STORE         = 16'h0040;
  localparam logic [15:0] CMD_COMBINE       = 16'h0061;
  localparam logic [15:0] CMD_IDENTIFY      = 16'h0063;
  localparam logic [15:0] CMD_MATCH_ONE     = 16'h0064;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_BAD_CHECK   = 3'd3,
    ST_UNKNOWN_CMD = 3'd4
  } frame_status_t;

  // one result word
  typedef struct packed {
    logic [2:0]  frame_status;
    logic [7:0]  matched_id_low;
    logic        backlight_request;
    logic [15:0] reply_value;
  } result_t;

endpackage

`default_nettype wire

// File: src/sensor_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker
// checks and decodes fingerprint module reply frames received byte by byte
// ----------------------------------------------------------------------------
// The block takes one reply byte per word on the slave stream, with tlast on
// the final byte of a frame, and gives one result word per frame on the master
// stream. A byte can be taken in every clock cycle unless a frame end meets a
// stalled result: header check, running 16-bit sum and field capture update on the
// accepting edge, and on the marked byte the verdict is formed from the updated
// frame state in the same cycle and lands in the output register, so the result
// appears in the cycle after the last byte. The output register parts both sides:
// a new byte is taken while a result still waits, as long as the result is taken
// in the same cycle or no further frame ends. Only the first 26 bytes of a frame
// are used; later bytes only end the frame. Failures give reply 0 with a status
// code naming the first failing check (short, header, checksum, command).
`timescale 1ns / 1ps
`default_nettype none

module sensor_reply_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tlast,   // frame_last
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [15:0] reply_value, [16] backlight_request,
                                      // [24:17] matched_id_low, [27:25] frame_status,
                                      // [31:28] zero
);
  import srfc_pkg::*;

  // frame state
  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_sum;
  logic             header_good;
  logic [15:0]      command_word;
  logic [15:0]      payload_word;
  logic [15:0]      received_check;
  logic [7:0]       stored_id_low;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_sum_next;
  logic             header_good_next;
  logic [15:0]      command_word_next;
  logic [15:0]      payload_word_next;
  logic [15:0]      received_check_next;
  logic [7:0]       stored_id_low_next;

  logic    take;      // a byte is accepted this cycle
  logic    in_frame;  // byte still inside the counted part of the frame
  result_t result_next;
  result_t result;

  // only a frame end needs the output register free
  assign s_tready = !m_tvalid || m_tready || !s_tlast;
  assign take     = s_tvalid && s_tready;
  assign in_frame = byte_position < POS_FULL;

  // byte capture: what the frame state becomes with the current byte
  always_comb begin
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    header_good_next    = header_good;
    command_word_next   = command_word;
    payload_word_next   = payload_word;
    received_check_next = received_check;
    if (in_frame) begin
      byte_position_next = byte_position + 5'd1;
      if (byte_position == POS_HDR0 && s_tdata != HDR_BYTE0) header_good_next = 1'b0;
      if (byte_position == POS_HDR1 && s_tdata != HDR_BYTE1) header_good_next = 1'b0;
      if (byte_position < POS_SUM) running_sum_next = running_sum + {8'd0, s_tdata};
      if (byte_position == POS_CMD_L) command_word_next[7:0]   = s_tdata;
      if (byte_position == POS_CMD_H) command_word_next[15:8]  = s_tdata;
      if (byte_position == POS_PAY_L) payload_word_next[7:0]   = s_tdata;
      if (byte_position == POS_PAY_H) payload_word_next[15:8]  = s_tdata;
      if (byte_position == POS_CHK_L) received_check_next[7:0]  = s_tdata;
      if (byte_position == POS_CHK_H) received_check_next[15:8] = s_tdata;
    end
  end

  // verdict from the updated frame state, used only on the marked byte
  always_comb begin
    frame_status_t status;
    logic [15:0]   reply;
    logic          light;
    status             = ST_OK;
    reply              = 16'd0;
    light              = 1'b0;
    stored_id_low_next = stored_id_low;
    priority if (byte_position_next < POS_FULL) begin
      status = ST_SHORT;
    end else if (!header_good_next) begin
      status = ST_BAD_HEADER;
    end else if (running_sum_next != received_check_next) begin
      status = ST_BAD_CHECK;
    end else begin
      unique case (command_word_next)
        CMD_STATUS: begin
          // id free unless the module answers taken
          if (payload_word_next[7:0] != ID_TAKEN) begin
            reply = 16'd1;
            light = 1'b1;
          end
        end
        CMD_IMAGE, CMD_MAKE_TEMPLATE, CMD_STORE, CMD_COMBINE: begin
          reply = 16'd1;
        end
        CMD_IDENTIFY, CMD_MATCH_ONE: begin
          reply              = payload_word_next;
          stored_id_low_next = payload_word_next[7:0];
        end
        default: begin
          status = ST_UNKNOWN_CMD;
        end
      endcase
    end
    result_next.reply_value       = reply;
    result_next.backlight_request = light;
    result_next.matched_id_low    = stored_id_low_next;
    result_next.frame_status      = status;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_sum    <= '0;
      header_good    <= 1'b1;
      command_word   <= '0;
      payload_word   <= '0;
      received_check <= '0;
      stored_id_low  <= '0;
    end else if (take) begin
      if (s_tlast) begin
        // end of frame: back to a clean frame, keep the last matched id
        byte_position  <= '0;
        running_sum    <= '0;
        header_good    <= 1'b1;
        command_word   <= '0;
        payload_word   <= '0;
        received_check <= '0;
        stored_id_low  <= stored_id_low_next;
      end else begin
        byte_position  <= byte_position_next;
        running_sum    <= running_sum_next;
        header_good    <= header_good_next;
        command_word   <= command_word_next;
        payload_word   <= payload_word_next;
        received_check <= received_check_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      result <= result_next;
    end
  end

  assign m_tdata = {4'd0, result};

endmodule

`default_nettype wire

// File: src/srfc_checker.sv
// ----------------------------------------------------------------------------
// srfc_checker
// port-level checks for the sensor reply frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  import srfc_pkg::*;

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a marked byte yields a result in the next cycle
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no result after end of frame");

  // no result without a frame end
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready && s_tlast) && (!m_tvalid || m_tready) |=> !m_tvalid)
    else $error("result without end of frame");

  // a failed frame gives reply zero and no backlight request
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27:25] != ST_OK |-> m_tdata[16:0] == 17'd0)
    else $error("failed frame with nonzero reply");

  // backlight request only with a free id answer
  a_light: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd1)
    else $error("backlight request without free id");

endmodule

bind sensor_reply_frame_checker srfc_checker u_srfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
